@@ rtl/lpnr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// linear-probe node registry. No dependencies.
`timescale 1ns / 1ps

package lpnr_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int POOL_ENTRIES  = 4096;
    localparam int MAX_PROBES    = 16;

    localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
    localparam int IDX_W    = 12;
    localparam int COUNT_W  = 13;
    localparam int PROBE_W  = $clog2(MAX_PROBES + 1);
    localparam int HASH_SH0 = 3;
    localparam int HASH_SH1 = 17;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SETPAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_LIMIT    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Source of the result node index.
    typedef enum logic [1:0] {
        NODE_ZERO  = 2'd0,
        NODE_COUNT = 2'd1,
        NODE_CHILD = 2'd2
    } node_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      clr_step;
        logic      slot_rd;
        logic      next_probe;
        logic      ins_commit;
        logic      par_wr;
        logic      pool_rd;
        logic      res_set;
        logic [1:0] res_status;
        node_sel_t res_node;
        logic      found_load;
        logic      out_load;
    } lpnr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_key_zero;
        logic pool_full;
        logic par_ok;
        logic slot_empty;
        logic slot_match;
        logic last_probe;
        logic node_ok;
        logic clr_last;
    } lpnr_stat_t;

endpackage

@@ rtl/lpnr_dp.sv @@
// Datapath of the registry: slot and pool memories, probe address, result
// and output registers. Depends on lpnr_pkg.
`timescale 1ns / 1ps

module lpnr_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lpnr_pkg::lpnr_cmd_t       cmd,
    output lpnr_pkg::lpnr_stat_t      stat,
    input  logic [63:0]               key,
    input  logic signed [31:0]        kind,
    input  logic signed [31:0]        node_flags,
    input  logic signed [31:0]        start_pos,
    input  logic signed [31:0]        end_pos,
    input  logic [11:0]               child_index,
    input  logic [11:0]               parent_index,
    input  logic                      parent_present,
    output logic [1:0]                status,
    output logic [11:0]               node_index,
    output logic signed [31:0]        found_kind,
    output logic signed [31:0]        found_flags,
    output logic signed [31:0]        found_start,
    output logic signed [31:0]        found_end,
    output logic                      found_has_parent,
    output logic [11:0]               found_parent,
    output logic [12:0]               nodes_in_use
);
    import lpnr_pkg::*;

    logic [63:0]         slot_key_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0]    slot_node_mem [TABLE_ENTRIES];
    logic [31:0]         pool_kind_mem [POOL_ENTRIES];
    logic [31:0]         pool_flags_mem [POOL_ENTRIES];
    logic [31:0]         pool_start_mem [POOL_ENTRIES];
    logic [31:0]         pool_end_mem [POOL_ENTRIES];
    logic [IDX_W:0]      pool_parent_mem [POOL_ENTRIES];

    logic [COUNT_W-1:0]  count_reg;
    logic [TABLE_AW-1:0] clr_reg;
    logic [63:0]         key_reg;
    logic [31:0]         kind_reg, flags_reg, start_reg, end_reg;
    logic [TABLE_AW-1:0] slot_reg;
    logic [PROBE_W-1:0]  probe_reg;
    logic [63:0]         rd_key_reg;
    logic [IDX_W-1:0]    rd_node_reg;
    logic [31:0]         rd_kind_reg, rd_flags_reg, rd_start_reg, rd_end_reg;
    logic [IDX_W:0]      rd_parent_reg;
    logic [1:0]          res_status_reg;
    logic [IDX_W-1:0]    res_node_reg;
    logic [31:0]         res_kind_reg, res_flags_reg, res_start_reg, res_end_reg;
    logic                res_hp_reg;
    logic [IDX_W-1:0]    res_parent_reg;
    logic [1:0]          out_status_reg;
    logic [IDX_W-1:0]    out_node_reg;
    logic [31:0]         out_kind_reg, out_flags_reg, out_start_reg, out_end_reg;
    logic                out_hp_reg;
    logic [IDX_W-1:0]    out_parent_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [63:0]         hash_mix;
    logic [TABLE_AW-1:0] slot_wr_addr;
    logic [63:0]         slot_wr_key;
    logic                slot_we;
    logic [IDX_W-1:0]    pool_wr_addr;
    logic [IDX_W-1:0]    par_addr;
    logic [IDX_W:0]      par_data;
    logic                par_we;
    logic [IDX_W-1:0]    node_pick;

    // Home slot of the incoming key.
    assign hash_mix = (key >> HASH_SH0) ^ (key >> HASH_SH1);

    // Status toward the controller.
    always_comb
    begin
        stat.in_key_zero = (key == 64'd0);
        stat.pool_full   = (count_reg >= COUNT_W'(POOL_ENTRIES));
        stat.par_ok      = ({1'b0, child_index} < COUNT_W'(POOL_ENTRIES)) &&
                           (!parent_present ||
                            ({1'b0, parent_index} < COUNT_W'(POOL_ENTRIES)));
        stat.slot_empty  = (rd_key_reg == 64'd0);
        stat.slot_match  = (rd_key_reg == key_reg);
        stat.last_probe  = (probe_reg == PROBE_W'(MAX_PROBES - 1));
        stat.node_ok     = ({1'b0, rd_node_reg} < COUNT_W'(POOL_ENTRIES));
        stat.clr_last    = (clr_reg == TABLE_AW'(TABLE_ENTRIES - 1));
    end

    // Slot and parent memory write ports: clearing pass, insert commit or set parent.
    always_comb
    begin
        slot_we      = cmd.clr_step || cmd.ins_commit;
        slot_wr_addr = cmd.clr_step ? clr_reg : slot_reg;
        slot_wr_key  = cmd.clr_step ? 64'd0 : key_reg;
        pool_wr_addr = count_reg[IDX_W-1:0];
        par_we       = cmd.par_wr || cmd.ins_commit;
        par_addr     = cmd.par_wr ? child_index : pool_wr_addr;
        par_data     = (cmd.par_wr && parent_present) ? {1'b1, parent_index} : '0;
    end

    // Slot memories.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_key_mem[slot_wr_addr] <= slot_wr_key;
        end
        if (cmd.ins_commit)
        begin
            slot_node_mem[slot_reg] <= pool_wr_addr;
        end
        if (cmd.slot_rd)
        begin
            rd_key_reg  <= slot_key_mem[slot_reg];
            rd_node_reg <= slot_node_mem[slot_reg];
        end
    end

    // Pool memories.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
        begin
            pool_kind_mem[pool_wr_addr]  <= kind_reg;
            pool_flags_mem[pool_wr_addr] <= flags_reg;
            pool_start_mem[pool_wr_addr] <= start_reg;
            pool_end_mem[pool_wr_addr]   <= end_reg;
        end
        if (par_we)
        begin
            pool_parent_mem[par_addr] <= par_data;
        end
        if (cmd.pool_rd)
        begin
            rd_kind_reg   <= pool_kind_mem[rd_node_reg];
            rd_flags_reg  <= pool_flags_mem[rd_node_reg];
            rd_start_reg  <= pool_start_mem[rd_node_reg];
            rd_end_reg    <= pool_end_mem[rd_node_reg];
            rd_parent_reg <= pool_parent_mem[rd_node_reg];
        end
    end

    // Control counters: pool fill count and clearing address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cmd.ins_commit)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + TABLE_AW'(1);
            end
        end
    end

    // Request capture and probe walk.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key;
            kind_reg  <= kind;
            flags_reg <= node_flags;
            start_reg <= start_pos;
            end_reg   <= end_pos;
            slot_reg  <= hash_mix[TABLE_AW-1:0];
            probe_reg <= '0;
        end
        else if (cmd.next_probe)
        begin
            slot_reg  <= slot_reg + TABLE_AW'(1);
            probe_reg <= probe_reg + PROBE_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.res_node)
            NODE_COUNT: node_pick = count_reg[IDX_W-1:0];
            NODE_CHILD: node_pick = child_index;
            default:    node_pick = '0;
        endcase
    end

    // Working result.
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_node_reg   <= node_pick;
            res_kind_reg   <= '0;
            res_flags_reg  <= '0;
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            res_hp_reg     <= 1'b0;
            res_parent_reg <= '0;
        end
        else if (cmd.found_load)
        begin
            res_status_reg <= ST_OK;
            res_node_reg   <= rd_node_reg;
            res_kind_reg   <= rd_kind_reg;
            res_flags_reg  <= rd_flags_reg;
            res_start_reg  <= rd_start_reg;
            res_end_reg    <= rd_end_reg;
            res_hp_reg     <= rd_parent_reg[IDX_W];
            res_parent_reg <= rd_parent_reg[IDX_W] ? rd_parent_reg[IDX_W-1:0] : '0;
        end
    end

    // Output register, held while the result transfer waits.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_node_reg   <= res_node_reg;
            out_kind_reg   <= res_kind_reg;
            out_flags_reg  <= res_flags_reg;
            out_start_reg  <= res_start_reg;
            out_end_reg    <= res_end_reg;
            out_hp_reg     <= res_hp_reg;
            out_parent_reg <= res_parent_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign status           = out_status_reg;
    assign node_index       = out_node_reg;
    assign found_kind       = out_kind_reg;
    assign found_flags      = out_flags_reg;
    assign found_start      = out_start_reg;
    assign found_end        = out_end_reg;
    assign found_has_parent = out_hp_reg;
    assign found_parent     = out_parent_reg;
    assign nodes_in_use     = out_count_reg;

endmodule

@@ rtl/lpnr_ctrl.sv @@
// Controller state machine of the registry: clearing pass, request
// dispatch, probe sequencing and output handshake. Depends on lpnr_pkg.
`timescale 1ns / 1ps

module lpnr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           req_type,
    input  lpnr_pkg::lpnr_stat_t stat,
    output lpnr_pkg::lpnr_cmd_t  cmd
);
    import lpnr_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PROBE  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_POOL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       ins_reg, ins_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_free  = !ovalid_reg || !out_stall;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        ins_next    = ins_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = '0;
        cmd.res_node = NODE_ZERO;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FINISH;
                    ins_next   = (req_type == REQ_INSERT);
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (stat.in_key_zero || stat.pool_full)
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (stat.in_key_zero)
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        REQ_SETPAR:
                        begin
                            cmd.res_set = 1'b1;
                            if (stat.par_ok)
                            begin
                                cmd.par_wr     = 1'b1;
                                cmd.res_status = ST_OK;
                                cmd.res_node   = NODE_CHILD;
                            end
                            else
                            begin
                                cmd.res_status = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_FINISH;
                if (ins_reg && stat.slot_empty)
                begin
                    cmd.ins_commit = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_node   = NODE_COUNT;
                end
                else if (!ins_reg && stat.slot_match)
                begin
                    if (stat.node_ok)
                    begin
                        cmd.pool_rd = 1'b1;
                        state_next  = S_POOL;
                    end
                    else
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                    end
                end
                else if (!ins_reg && stat.slot_empty)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                end
                else if (stat.last_probe)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_LIMIT;
                end
                else
                begin
                    cmd.next_probe = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_POOL:
            begin
                cmd.found_load = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ins_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ins_reg    <= ins_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

@@ rtl/linear_probe_node_registry.sv @@
// Top level of the linear-probe node registry: controller plus datapath.
// Depends on lpnr_pkg, lpnr_ctrl and lpnr_dp.
//
//   Channel  Direction  Handshake            Payload
//   request  in         in_valid / in_stall  req_type, key, kind, node_flags,
//                                            start_pos, end_pos, child_index,
//                                            parent_index, parent_present
//   result   out        out_valid/out_stall  status, node_index, found_*,
//                                            nodes_in_use
//
// Insert and lookup take a slot memory read, then a compare, for each probe,
// up to 16 probes; a lookup hit adds one pool read. Set parent and rejected
// requests skip the probe walk. After reset a clearing pass writes all 4096
// slot keys to zero, with in_stall high. A stalled result waits in the
// output register; the next request transfer is taken while it waits.
`timescale 1ns / 1ps

module linear_probe_node_registry (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [63:0]        key,
    input  logic signed [31:0] kind,
    input  logic signed [31:0] node_flags,
    input  logic signed [31:0] start_pos,
    input  logic signed [31:0] end_pos,
    input  logic [11:0]        child_index,
    input  logic [11:0]        parent_index,
    input  logic               parent_present,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [11:0]        node_index,
    output logic signed [31:0] found_kind,
    output logic signed [31:0] found_flags,
    output logic signed [31:0] found_start,
    output logic signed [31:0] found_end,
    output logic               found_has_parent,
    output logic [11:0]        found_parent,
    output logic [12:0]        nodes_in_use
);
    import lpnr_pkg::*;

    lpnr_cmd_t  cmd;
    lpnr_stat_t stat;

    lpnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .req_type  (req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpnr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .key              (key),
        .kind             (kind),
        .node_flags       (node_flags),
        .start_pos        (start_pos),
        .end_pos          (end_pos),
        .child_index      (child_index),
        .parent_index     (parent_index),
        .parent_present   (parent_present),
        .status           (status),
        .node_index       (node_index),
        .found_kind       (found_kind),
        .found_flags      (found_flags),
        .found_start      (found_start),
        .found_end        (found_end),
        .found_has_parent (found_has_parent),
        .found_parent     (found_parent),
        .nodes_in_use     (nodes_in_use)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the linear-probe node registry.
// Depends on lpnr_pkg and linear_probe_node_registry; uses a built-in predictor.
`timescale 1ns / 1ps

module testbench;
    import lpnr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1120;

    typedef struct {
        logic [1:0]         req;
        logic [63:0]        k;
        logic signed [31:0] knd;
        logic signed [31:0] flg;
        logic signed [31:0] st;
        logic signed [31:0] en;
        logic [11:0]        child;
        logic [11:0]        parent;
        logic               present;
        bit                 typed;
        logic [1:0]         t_status;
        logic [11:0]        t_node;
        logic [12:0]        t_count;
    } request_t;

    typedef struct {
        logic [1:0]         status;
        logic [11:0]        node;
        logic signed [31:0] fkind;
        logic signed [31:0] fflags;
        logic signed [31:0] fstart;
        logic signed [31:0] fend;
        logic               fhas;
        logic [11:0]        fpar;
        logic [12:0]        count;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic [63:0]        key;
    logic signed [31:0] kind;
    logic signed [31:0] node_flags;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [11:0]        child_index;
    logic [11:0]        parent_index;
    logic               parent_present;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [11:0]        node_index;
    logic signed [31:0] found_kind;
    logic signed [31:0] found_flags;
    logic signed [31:0] found_start;
    logic signed [31:0] found_end;
    logic               found_has_parent;
    logic [11:0]        found_parent;
    logic [12:0]        nodes_in_use;

    // Shadow copy of the registry.
    logic [63:0] shadow_key [TABLE_ENTRIES];
    logic [11:0] shadow_node [TABLE_ENTRIES];
    logic [31:0] shadow_kind [POOL_ENTRIES];
    logic [31:0] shadow_flags [POOL_ENTRIES];
    logic [31:0] shadow_start [POOL_ENTRIES];
    logic [31:0] shadow_end [POOL_ENTRIES];
    logic [12:0] shadow_parent [POOL_ENTRIES];
    int          shadow_count;

    answer_t     pending_answers [$];
    logic [63:0] known_keys [$];
    int          errors;
    int          idle_cycles;
    int          hold_len;
    bit          quiet;
    int          n_ok, n_limit, n_full, n_miss;

    linear_probe_node_registry i_dut (.*);

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Expected behavior of one request; updates the shadow state.
    function automatic answer_t registry_predict(request_t r);
        answer_t a;
        int home, s;
        int n;
        a = '{default: '0};
        a.status = ST_NOTFOUND;
        if (r.req == REQ_INSERT) begin
            if (r.k == 64'd0 || shadow_count >= POOL_ENTRIES) begin
                a.status = ST_FULL;
            end
            else begin
                home = int'(((r.k >> 3) ^ (r.k >> 17)) & (TABLE_ENTRIES - 1));
                a.status = ST_LIMIT;
                for (int i = 0; i < MAX_PROBES; i++) begin
                    s = (home + i) & (TABLE_ENTRIES - 1);
                    if (shadow_key[s] == 64'd0) begin
                        n = shadow_count;
                        shadow_kind[n] = r.knd;
                        shadow_flags[n] = r.flg;
                        shadow_start[n] = r.st;
                        shadow_end[n] = r.en;
                        shadow_parent[n] = '0;
                        shadow_count = n + 1;
                        shadow_key[s] = r.k;
                        shadow_node[s] = n[11:0];
                        a.status = ST_OK;
                        a.node = n[11:0];
                        break;
                    end
                end
            end
        end
        else if (r.req == REQ_LOOKUP) begin
            if (r.k != 64'd0) begin
                home = int'(((r.k >> 3) ^ (r.k >> 17)) & (TABLE_ENTRIES - 1));
                a.status = ST_LIMIT;
                for (int i = 0; i < MAX_PROBES; i++) begin
                    s = (home + i) & (TABLE_ENTRIES - 1);
                    if (shadow_key[s] == r.k) begin
                        n = int'(shadow_node[s]);
                        a.status = ST_OK;
                        a.node = n[11:0];
                        a.fkind = shadow_kind[n];
                        a.fflags = shadow_flags[n];
                        a.fstart = shadow_start[n];
                        a.fend = shadow_end[n];
                        a.fhas = shadow_parent[n][12];
                        a.fpar = a.fhas ? shadow_parent[n][11:0] : 12'd0;
                        break;
                    end
                    if (shadow_key[s] == 64'd0) begin
                        a.status = ST_NOTFOUND;
                        break;
                    end
                end
            end
        end
        else if (r.req == REQ_SETPAR) begin
            // Both indexes are 12 bits wide, so they are always in range.
            shadow_parent[r.child] = r.present ? {1'b1, r.parent} : 13'd0;
            a.status = ST_OK;
            a.node = r.child;
        end
        a.count = shadow_count[12:0];
        return a;
    endfunction

    task automatic compare_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // Offers one request after a gap, waits for its transfer, records its answer.
    task automatic send_request(request_t r, int gap);
        answer_t a;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.req;
        key <= r.k;
        kind <= r.knd;
        node_flags <= r.flg;
        start_pos <= r.st;
        end_pos <= r.en;
        child_index <= r.child;
        parent_index <= r.parent;
        parent_present <= r.present;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        a = registry_predict(r);
        if (r.typed) begin
            compare_field("table status", r.t_status, a.status);
            compare_field("table node", r.t_node, a.node);
            compare_field("table count", r.t_count, a.count);
        end
        if (r.req == REQ_INSERT && a.status == ST_OK) known_keys.push_back(r.k);
        case (a.status)
            ST_OK:    n_ok++;
            ST_LIMIT: n_limit++;
            ST_FULL:  n_full++;
            default:  n_miss++;
        endcase
        pending_answers.push_back(a);
    endtask

    function automatic request_t make_row(logic [1:0] rq, logic [63:0] k, bit typed,
                                          logic [1:0] ts, logic [11:0] tn,
                                          logic [12:0] tc);
        request_t r;
        r = '{default: '0};
        r.req = rq;
        r.k = k;
        r.knd = $urandom;
        r.flg = $urandom;
        r.st = $urandom;
        r.en = $urandom;
        r.typed = typed;
        r.t_status = ts;
        r.t_node = tn;
        r.t_count = tc;
        return r;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
            end
            else begin
                n = draw_gap();
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Checks each result transfer against the oldest expected answer.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result transfer with no request outstanding", $time);
                errors++;
            end
            else begin
                e = pending_answers.pop_front();
                compare_field("status", e.status, status);
                compare_field("node_index", e.node, node_index);
                compare_field("found_kind", e.fkind, found_kind);
                compare_field("found_flags", e.fflags, found_flags);
                compare_field("found_start", e.fstart, found_start);
                compare_field("found_end", e.fend, found_end);
                compare_field("found_has_parent", e.fhas, found_has_parent);
                compare_field("found_parent", e.fpar, found_parent);
                compare_field("nodes_in_use", e.count, nodes_in_use);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** linear_probe_node_registry: FAILED **");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed table, then random traffic.
    initial
    begin
        request_t rows [$];
        request_t r;
        int sel;
        errors = 0;
        idle_cycles = 0;
        hold_len = 0;
        quiet = 0;
        n_ok = 0;
        n_limit = 0;
        n_full = 0;
        n_miss = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) shadow_key[i] = '0;
        shadow_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        key = '0;
        kind = '0;
        node_flags = '0;
        start_pos = '0;
        end_pos = '0;
        child_index = '0;
        parent_index = '0;
        parent_present = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Key zero, empty table, all-ones key with extreme payload.
        rows.push_back(make_row(REQ_LOOKUP, 64'd0, 1, ST_NOTFOUND, 12'd0, 13'd0));
        rows.push_back(make_row(REQ_INSERT, 64'd0, 1, ST_FULL, 12'd0, 13'd0));
        rows.push_back(make_row(REQ_LOOKUP, '1, 1, ST_NOTFOUND, 12'd0, 13'd0));
        r = make_row(REQ_INSERT, '1, 1, ST_OK, 12'd0, 13'd1);
        r.knd = 32'sh8000_0000;
        r.flg = 32'sh7fff_ffff;
        r.st = '1;
        r.en = '0;
        rows.push_back(r);
        rows.push_back(make_row(REQ_LOOKUP, '1, 0, 0, 0, 0));
        r = make_row(REQ_SETPAR, 64'd0, 1, ST_OK, 12'd0, 13'd1);
        r.parent = 12'hfff;
        r.present = 1'b1;
        rows.push_back(r);
        rows.push_back(make_row(REQ_LOOKUP, '1, 0, 0, 0, 0));
        r = make_row(REQ_SETPAR, '1, 1, ST_OK, 12'hfff, 13'd1);
        r.child = 12'hfff;
        r.parent = 12'hfff;
        rows.push_back(r);
        rows.push_back(make_row(2'd3, '1, 1, ST_NOTFOUND, 12'd0, 13'd1));
        // Keys j<<32 all share home slot zero with the all-ones key.
        for (int j = 1; j <= 16; j++) begin
            if (j < 16) begin
                rows.push_back(make_row(REQ_INSERT, 64'(j) << 32, 1, ST_OK, 12'(j), 13'(j + 1)));
            end
            else begin
                rows.push_back(make_row(REQ_INSERT, 64'(j) << 32, 1, ST_LIMIT, 12'd0, 13'd16));
            end
        end
        rows.push_back(make_row(REQ_LOOKUP, 64'd17 << 32, 1, ST_LIMIT, 12'd0, 13'd16));
        rows.push_back(make_row(REQ_LOOKUP, 64'd7 << 32, 0, 0, 0, 0));
        // A link set on an unallocated entry is cleared by the insert there.
        r = make_row(REQ_SETPAR, 64'd0, 1, ST_OK, 12'd16, 13'd16);
        r.child = 12'd16;
        r.parent = 12'd3;
        r.present = 1'b1;
        rows.push_back(r);
        rows.push_back(make_row(REQ_INSERT, 64'd40, 1, ST_OK, 12'd16, 13'd17));
        rows.push_back(make_row(REQ_LOOKUP, 64'd40, 0, 0, 0, 0));
        foreach (rows[i]) send_request(rows[i], draw_gap());

        // Random traffic with stretches of no idling on either side.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = ((i / 100) % 4) == 3;
            if (i == 300) hold_len = 400;
            if (i == 650) begin
                in_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge clk);
            end
            r = make_row(REQ_INSERT, {$urandom, $urandom}, 0, 0, 0, 0);
            if ($urandom_range(0, 3) == 0) r.k = 64'($urandom_range(1, 40)) << 32;
            if ($urandom_range(0, 7) == 0) r.k = 64'($urandom_range(0, 255)) << 3;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                r.req = REQ_INSERT;
            end
            else if (sel < 78) begin
                r.req = REQ_LOOKUP;
                if (known_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
                    r.k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                end
            end
            else if (sel < 95) begin
                r.req = REQ_SETPAR;
            end
            else begin
                r.req = 2'd3;
            end
            r.child = 12'($urandom);
            r.parent = 12'($urandom);
            r.present = 1'($urandom);
            if ($urandom_range(0, 1) == 0) r.child = 12'($urandom_range(0, shadow_count));
            send_request(r, draw_gap());
        end
        in_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d ok, %0d not found, %0d probe limit, %0d full or key zero.",
                 n_ok, n_miss, n_limit, n_full);
        $display("Pool reached %0d entries; random stalls on both sides.", shadow_count);
        if (errors == 0) begin
            $display("** linear_probe_node_registry: PASSED **");
        end
        else begin
            $display("** linear_probe_node_registry: FAILED **");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/lpnr_pkg.sv
rtl/lpnr_dp.sv
rtl/lpnr_ctrl.sv
rtl/linear_probe_node_registry.sv
test/testbench.sv
